FILE: src/tsqb_pkg.sv
// shared types and constants for the threshold select quintic blend block
package tsqb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int FALLOFF_W     = 31;
    localparam int NUM_W         = 33;
    localparam int DEN_W         = 32;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLOFF   = 2'd1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_HIGH,
        SEL_BLEND
    } t_sel;

    typedef struct packed {
        t_sel                     sel;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } t_pay;

    typedef struct packed {
        t_pay             pay;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_item;

    typedef struct packed {
        logic [QAW:0] count;
        logic         push;
        logic         pop;
    } t_q_status;

endpackage

FILE: src/tsqb_front.sv
// front end: configuration registers and band classification of each item
module tsqb_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tsqb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tsqb_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic signed [tsqb_pkg::DATA_W-1:0] i_control,
    input  logic signed [tsqb_pkg::DATA_W-1:0] i_low_value,
    input  logic signed [tsqb_pkg::DATA_W-1:0] i_high_value,
    output tsqb_pkg::t_item                o_item
);
    import tsqb_pkg::*;

    logic signed [DATA_W-1:0] r_threshold;
    logic [FALLOFF_W-1:0]     r_falloff;

    logic signed [33:0] ctl_w;
    logic signed [33:0] thr_w;
    logic signed [33:0] f_w;
    logic signed [33:0] lo_lim;
    logic signed [33:0] hi_lim;
    logic signed [33:0] num_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_falloff   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_threshold <= i_cfg_data;
                REG_FALLOFF:   r_falloff   <= i_cfg_data[FALLOFF_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        ctl_w  = {{2{i_control[DATA_W-1]}}, i_control};
        thr_w  = {{2{r_threshold[DATA_W-1]}}, r_threshold};
        f_w    = {3'b000, r_falloff};
        lo_lim = thr_w - f_w;
        hi_lim = thr_w + f_w;
        num_w  = ctl_w - lo_lim;

        o_item.pay.lo = i_low_value;
        o_item.pay.hi = i_high_value;
        o_item.num    = num_w[NUM_W-1:0];
        o_item.den    = {r_falloff, 1'b0};

        if (r_falloff == '0) begin
            o_item.pay.sel = (ctl_w < thr_w) ? SEL_LOW : SEL_HIGH;
        end else if (ctl_w < lo_lim) begin
            o_item.pay.sel = SEL_LOW;
        end else if (ctl_w > hi_lim) begin
            o_item.pay.sel = SEL_HIGH;
        end else begin
            o_item.pay.sel = SEL_BLEND;
        end
    end

endmodule

FILE: src/tsqb_queue.sv
// short queue between the classifying front end and the blend pipeline
module tsqb_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tsqb_pkg::t_item     i_item,
    output logic                o_ready,
    output logic                o_valid,
    output tsqb_pkg::t_item     o_item,
    input  logic                i_pop,
    output tsqb_pkg::t_q_status o_status
);
    import tsqb_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;
    logic [QAW:0]   n_count;
    logic           push_ok;
    logic           pop_ok;

    assign o_ready = (r_count != (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_status.count = r_count;
    assign o_status.push  = push_ok;
    assign o_status.pop   = pop_ok;

endmodule

FILE: src/tsqb_back.sv
// back end: pipelined divider, quintic smoothstep and blend with output register
module tsqb_back #(
    parameter int FRAC_BITS = tsqb_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  tsqb_pkg::t_item                i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tsqb_pkg::DATA_W-1:0]    o_result
);
    import tsqb_pkg::*;

    localparam int TW  = FRAC_BITS + 1;
    localparam int DS  = TW;
    localparam int EW  = FRAC_BITS + 4;
    localparam int RW  = 34;
    localparam int PTT = 2 * TW;
    localparam int PE  = EW + TW;
    localparam int PDW = 34 + TW;

    localparam logic [TW-1:0]         ONE_T   = TW'(1) << FRAC_BITS;
    localparam logic [EW-1:0]         K10     = EW'(10) << FRAC_BITS;
    localparam logic [EW-1:0]         K15     = EW'(15) << FRAC_BITS;
    localparam logic [PTT-1:0]        HALF_TT = PTT'(1) << (FRAC_BITS - 1);
    localparam logic [PE-1:0]         HALF_E  = PE'(1) << (FRAC_BITS - 1);
    localparam logic signed [PDW-1:0] HALF_P  = PDW'(1) << (FRAC_BITS - 1);

    logic adv;

    // divider stages, one quotient bit each
    logic          r_qv   [DS];
    t_pay          r_qp   [DS];
    logic [RW-1:0] r_qrem [DS];
    logic [RW-1:0] r_qden [DS];
    logic [TW-1:0] r_quo  [DS];

    // smoothstep and blend stages
    logic          r_av, r_bv, r_cv, r_mv, r_ov;
    t_pay          r_ap, r_bp, r_cp, r_mp;
    logic [TW-1:0] r_at, r_ac, r_bd, r_cs;
    logic [EW-1:0] r_ae, r_bb;
    logic signed [PDW-1:0] r_mprod;
    logic [DATA_W-1:0]     r_ores;

    logic [TW-1:0]  t_val;
    logic [PTT-1:0] a_tt, a_c_full;
    logic [EW-1:0]  a_six, a_m;
    logic [PE-1:0]  a_pe, a_e_full;
    logic [PTT-1:0] b_pd, b_d_full;
    logic [PE-1:0]  c_ps, c_s_full;
    logic signed [32:0]    m_diff;
    logic signed [PDW-1:0] m_a, m_b;
    logic signed [PDW-1:0] o_sum, o_sh;
    logic [DATA_W-1:0]     n_res;

    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && i_valid;

    genvar k;
    generate
        for (k = 0; k < DS; k++) begin : g_div
            logic [RW-1:0] rem_in;
            logic [RW-1:0] den_in;
            logic [TW-1:0] quo_in;
            logic          vin;
            t_pay          pin;
            logic          ge;
            logic [RW-1:0] rem_sub;

            if (k == 0) begin : g_first
                assign rem_in = {1'b0, i_item.num};
                assign den_in = {2'b00, i_item.den};
                assign quo_in = '0;
                assign vin    = i_valid;
                assign pin    = i_item.pay;
            end else begin : g_next
                assign rem_in = r_qrem[k-1];
                assign den_in = r_qden[k-1];
                assign quo_in = r_quo[k-1];
                assign vin    = r_qv[k-1];
                assign pin    = r_qp[k-1];
            end

            assign ge      = (rem_in >= den_in);
            assign rem_sub = ge ? (rem_in - den_in) : rem_in;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_qv[k] <= 1'b0;
                end else if (adv) begin
                    r_qv[k] <= vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_qp[k]   <= pin;
                    r_qrem[k] <= {rem_sub[RW-2:0], 1'b0};
                    r_qden[k] <= den_in;
                    r_quo[k]  <= {quo_in[TW-2:0], ge};
                end
            end
        end
    endgenerate

    always_comb begin
        t_val    = r_quo[DS-1];
        a_tt     = PTT'(t_val) * PTT'(t_val);
        a_c_full = (a_tt + HALF_TT) >> FRAC_BITS;
        a_six    = (EW'(t_val) << 2) + (EW'(t_val) << 1);
        a_m      = K15 - a_six;
        a_pe     = PE'(a_m) * PE'(t_val);
        a_e_full = (a_pe + HALF_E) >> FRAC_BITS;

        b_pd     = PTT'(r_ac) * PTT'(r_at);
        b_d_full = (b_pd + HALF_TT) >> FRAC_BITS;

        c_ps     = PE'(r_bd) * PE'(r_bb);
        c_s_full = (c_ps + HALF_E) >> FRAC_BITS;

        m_diff   = {r_cp.hi[DATA_W-1], r_cp.hi} - {r_cp.lo[DATA_W-1], r_cp.lo};
        m_a      = {{(PDW-33){m_diff[32]}}, m_diff};
        m_b      = {{(PDW-TW){1'b0}}, r_cs};

        o_sum    = r_mprod + HALF_P;
        o_sh     = o_sum >>> FRAC_BITS;
    end

    always_comb begin
        case (r_mp.sel)
            SEL_LOW:   n_res = r_mp.lo;
            SEL_HIGH:  n_res = r_mp.hi;
            SEL_BLEND: n_res = r_mp.lo + o_sh[DATA_W-1:0];
            default:   n_res = r_mp.lo;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_av <= r_qv[DS-1];
            r_bv <= r_av;
            r_cv <= r_bv;
            r_mv <= r_cv;
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ap    <= r_qp[DS-1];
            r_at    <= t_val;
            r_ac    <= a_c_full[TW-1:0];
            r_ae    <= a_e_full[EW-1:0];
            r_bp    <= r_ap;
            r_bd    <= b_d_full[TW-1:0];
            r_bb    <= K10 - r_ae;
            r_cp    <= r_bp;
            r_cs    <= (c_s_full > PE'(ONE_T)) ? ONE_T : c_s_full[TW-1:0];
            r_mp    <= r_cp;
            r_mprod <= m_a * m_b;
            r_ores  <= n_res;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_ores;

endmodule

FILE: src/threshold_select_quintic_blend.sv
// top level of the threshold select block with quintic smoothstep blend
//
// input channel: i_in_valid / o_in_ready with i_control, i_low_value and
// i_high_value, all signed Q16.16; output channel: o_out_valid / i_out_ready
// with o_result. a transfer happens when valid and ready are both high.
// threshold (index 0) and falloff (index 1) are written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must write them only while no item
// is in flight, the block itself does not enforce it; other indexes are ignored.
// throughput is one item per cycle while the receiver does not stall. the
// pipeline is the restoring divider, one quotient bit per stage, followed
// by four multiply stages and the output register.
// items are classified on entry and wait in a four-entry queue; when the
// receiver stalls the pipeline holds, the queue fills and o_in_ready drops
// once it is full.
// reset clears the configuration registers to zero, empties the queue and the pipeline.
module threshold_select_quintic_blend #(
    parameter int FRAC_BITS = tsqb_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tsqb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsqb_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [tsqb_pkg::DATA_W-1:0] i_control,
    input  logic signed [tsqb_pkg::DATA_W-1:0] i_low_value,
    input  logic signed [tsqb_pkg::DATA_W-1:0] i_high_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [tsqb_pkg::DATA_W-1:0] o_result
);
    import tsqb_pkg::*;

    t_item     front_item;
    t_item     head_item;
    logic      head_valid;
    logic      back_pop;
    t_q_status q_st;
    logic [DATA_W-1:0] back_result;

    tsqb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_control    (i_control),
        .i_low_value  (i_low_value),
        .i_high_value (i_high_value),
        .o_item       (front_item)
    );

    tsqb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_in_valid),
        .i_item   (front_item),
        .o_ready  (o_in_ready),
        .o_valid  (head_valid),
        .o_item   (head_item),
        .i_pop    (back_pop),
        .o_status (q_st)
    );

    tsqb_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_item   (head_item),
        .o_pop    (back_pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (back_result)
    );

    assign o_result = back_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_st.count <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_st.pop |-> (q_st.count != '0))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_st.push && !q_st.pop) |=> (q_st.count == $past(q_st.count) + 1'b1))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_st.pop && !q_st.push) |=> (q_st.count == $past(q_st.count) - 1'b1))
        else $error("queue count missed a pop");

endmodule

FILE: tb/sv/tb_threshold_select_quintic_blend.sv
// testbench for the threshold select block with quintic smoothstep blend
`timescale 1ns / 1ps

module tb_threshold_select_quintic_blend;
    import tsqb_pkg::*;

    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam longint unsigned ONE_U = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF_U = 64'd1 << (FRAC_BITS - 1);
    localparam longint HALF_S = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint CTL_MAX = 64'sd2147483647;
    localparam longint CTL_MIN = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int MAX_IDLE = 11;
    localparam int DRAIN_CYCLES = FRAC_BITS + 14;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_ITEMS = 75;
    localparam int DIR_ROWS = 24;

    localparam logic [31:0] MIN_V = 32'h8000_0000;
    localparam logic [31:0] MAX_V = 32'h7fff_ffff;
    localparam logic [31:0] SA = 32'h1111_1111;
    localparam logic [31:0] SB = 32'h2222_2222;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;
    localparam logic [30:0] F_ONE = 31'h0001_0000;
    localparam logic [30:0] F_MAX = 31'h7fff_ffff;
    localparam logic [31:0] T_MID = 32'h1234_5678;

    typedef struct packed {
        logic [31:0] thr;
        logic [30:0] fall;
        logic [31:0] ctl;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        known;
        logic [31:0] want;
    } t_dir_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [DATA_W-1:0]         i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [DATA_W-1:0]  i_control = '0;
    logic signed [DATA_W-1:0]  i_low_value = '0;
    logic signed [DATA_W-1:0]  i_high_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [DATA_W-1:0]  o_result;

    logic signed [31:0] threshold_q = '0;
    logic [30:0]        falloff_q = '0;
    logic [31:0]        pending_results[$];
    logic [31:0]        due_result;
    t_dir_row           dir_rows [DIR_ROWS];
    int                 error_count = 0;
    int                 stall_left = 0;
    bit                 no_idle = 1'b0;

    threshold_select_quintic_blend #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_control   (i_control),
        .i_low_value (i_low_value),
        .i_high_value(i_high_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint unsigned q_mul(longint unsigned x, longint unsigned y);
        return (x * y + HALF_U) >> FRAC_BITS;
    endfunction

    function automatic longint unsigned smoothstep5(longint unsigned t);
        longint unsigned sq, cube, poly, s;
        sq = q_mul(t, t);
        cube = q_mul(sq, t);
        poly = 10 * ONE_U - q_mul(15 * ONE_U - 6 * t, t);
        s = q_mul(cube, poly);
        return (s > ONE_U) ? ONE_U : s;
    endfunction

    function automatic logic [31:0] blend_predict(logic [31:0] ctl_in, logic [31:0] lo_in,
                                                  logic [31:0] hi_in);
        longint ctl, lo, hi, th, f, prod, res;
        longint unsigned num, den, t, s;
        ctl = $signed(ctl_in);
        lo = $signed(lo_in);
        hi = $signed(hi_in);
        th = threshold_q;
        f = longint'(falloff_q);
        if (f == 0) begin
            res = (ctl < th) ? lo : hi;
        end else if (ctl < th - f) begin
            res = lo;
        end else if (ctl > th + f) begin
            res = hi;
        end else begin
            num = ctl - th + f;
            den = 2 * f;
            t = (num << FRAC_BITS) / den;
            s = smoothstep5(t);
            prod = (hi - lo) * longint'(s);
            res = lo + ((prod + HALF_S) >>> FRAC_BITS);
        end
        return res[31:0];
    endfunction

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return MIN_V;
            1: return MAX_V;
            2: return 32'($urandom_range(0, 32'h3_ffff)) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_control();
        longint th, f, c;
        int sel;
        th = threshold_q;
        f = longint'(falloff_q);
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            c = longint'($signed($urandom));
        end else if (f == 0) begin
            c = th + longint'($urandom_range(0, 2)) - 1;
        end else if (sel < 50) begin
            case ($urandom_range(0, 3))
                0: c = th - f;
                1: c = th + f;
                2: c = th - f - 1;
                default: c = th + f + 1;
            endcase
        end else begin
            c = th - f + longint'({$urandom, $urandom} % unsigned'(2 * f + 1));
        end
        if (c > CTL_MAX) c = CTL_MAX;
        if (c < CTL_MIN) c = CTL_MIN;
        return c[31:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_THRESHOLD: threshold_q = data;
            REG_FALLOFF:   falloff_q = data[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_levels(logic [31:0] thr, logic [30:0] fall);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FALLOFF, {1'($urandom_range(0, 1)), fall});
        write_reg(REG_SPARE_B, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_item(logic [31:0] ctl, logic [31:0] lo, logic [31:0] hi,
                             logic [31:0] want);
        int gap;
        gap = idle_cycles();
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_control <= ctl;
        i_low_value <= lo;
        i_high_value <= hi;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(want);
    endtask

    // result side: random stalls and in-order checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result: no transfer expected, actual %h", o_result);
                    error_count++;
                end else begin
                    due_result = pending_results.pop_front();
                    if (o_result !== due_result) begin
                        $error("result: expected %h, actual %h", due_result, o_result);
                        error_count++;
                    end
                end
                stall_left = idle_cycles();
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [30:0] fall;
        logic [31:0] ctl, lo, hi;
        dir_rows = '{
            '{32'h0, 31'h0, 32'hffff_ffff, SA, SB, 1'b1, SA},
            '{32'h0, 31'h0, 32'h0, SA, SB, 1'b1, SB},
            '{32'h0, 31'h0, MIN_V, SA, SB, 1'b1, SA},
            '{32'h0, 31'h0, MAX_V, SA, SB, 1'b1, SB},
            '{32'h0, 31'h0, 32'hffff_fffb, MIN_V, MAX_V, 1'b1, MIN_V},
            '{32'h0, 31'h0, 32'h5, MIN_V, MAX_V, 1'b1, MAX_V},
            '{MAX_V, 31'h0, MAX_V, SA, SB, 1'b1, SB},
            '{MAX_V, 31'h0, 32'h7fff_fffe, SA, SB, 1'b1, SA},
            '{MIN_V, 31'h0, MIN_V, SA, SB, 1'b1, SB},
            '{32'h0, F_ONE, 32'hffff_0000, MIN_V, MAX_V, 1'b1, MIN_V},
            '{32'h0, F_ONE, ONE_Q, MIN_V, MAX_V, 1'b1, MAX_V},
            '{32'h0, F_ONE, 32'hfffe_ffff, SA, SB, 1'b1, SA},
            '{32'h0, F_ONE, 32'h0001_0001, SA, SB, 1'b1, SB},
            '{32'h0, F_ONE, 32'h0, MIN_V, MAX_V, 1'b0, 32'h0},
            '{32'h0, F_ONE, 32'h0000_8000, SB, SA, 1'b0, 32'h0},
            '{MAX_V, F_MAX, MAX_V, MIN_V, MAX_V, 1'b0, 32'h0},
            '{MAX_V, F_MAX, 32'h0, SA, SB, 1'b1, SA},
            '{MAX_V, F_MAX, MIN_V, SA, SB, 1'b1, SA},
            '{MIN_V, F_MAX, 32'hffff_ffff, SA, SB, 1'b1, SB},
            '{MIN_V, F_MAX, MAX_V, SA, SB, 1'b1, SB},
            '{MIN_V, F_MAX, MIN_V, MAX_V, MIN_V, 1'b0, 32'h0},
            '{T_MID, 31'h1, T_MID - 32'h1, SA, SB, 1'b1, SA},
            '{T_MID, 31'h1, T_MID, 32'h0, 32'hffff_0000, 1'b0, 32'h0},
            '{T_MID, 31'h1, T_MID + 32'h1, SA, SB, 1'b1, SB}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].thr !== threshold_q || dir_rows[r].fall !== falloff_q) begin
                wait_drained();
                set_levels(dir_rows[r].thr, dir_rows[r].fall);
            end
            send_item(dir_rows[r].ctl, dir_rows[r].lo, dir_rows[r].hi,
                      dir_rows[r].known ? dir_rows[r].want
                                        : blend_predict(dir_rows[r].ctl, dir_rows[r].lo,
                                                        dir_rows[r].hi));
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            no_idle = (phase % 4 == 1);
            case ($urandom_range(0, 4))
                0: fall = '0;
                1: fall = F_MAX;
                2: fall = 31'($urandom_range(1, 255));
                3: fall = 31'($urandom_range(1, 32'h2_0000));
                default: fall = 31'($urandom);
            endcase
            case (phase)
                0: set_levels(MIN_V, F_MAX);
                1: set_levels(MAX_V, '0);
                2: set_levels(32'h0, 31'h1);
                3: set_levels(MAX_V, F_MAX);
                default: set_levels(pick_sample(), fall);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0) wait_drained();
                ctl = pick_control();
                lo = pick_sample();
                hi = pick_sample();
                send_item(ctl, lo, hi, blend_predict(ctl, lo, hi));
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
